### sv/fpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_pkg
// Types and constants shared by the file permission table and its decision
// logic.
// ----------------------------------------------------------------------------
package fpt_pkg;

	// request kinds carried on s_tuser
	typedef enum logic {
		REQ_SET   = 1'b0,
		REQ_CHECK = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_EXEC  = 2'd2,
		ACT_BAD   = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DENIED   = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_BADACT   = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} fsm_t;

	localparam int PERM_W = 9;

	// s_tdata layout, lowest bit first
	localparam int KEY_LSB   = 0;
	localparam int KEY_IN_W  = 64;
	localparam int OWN_LSB   = 64;
	localparam int ID_IN_W   = 32;
	localparam int PERM_LSB  = 96;
	localparam int USER_LSB  = 105;
	localparam int GRP_BIT   = 137;
	localparam int ACT_LSB   = 138;
	localparam int IN_DATA_W = 144;
	localparam int OUT_DATA_W = 8;

	// what the scan found, handed to the decision logic
	typedef struct packed {
		req_t                    req_type;
		logic                    found;
		logic                    full;
		logic                    owner_match;
		logic                    is_group;
		act_t                    action;
		logic [PERM_W-1:0]       perm;
	} lookup_t;

	typedef struct packed {
		logic    ok;
		status_t status;
		logic    wr_en;
		logic    append;
	} result_t;

endpackage

### sv/file_permission_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_permission_table
// Access-control table of file keys, owners and rwx bits with set and check
// requests.
// ----------------------------------------------------------------------------
// Usage:
//   One request enters on the s_ channel (s_tuser selects set or check) and
//   gives exactly one response on the m_ channel (ok and status).
//   Records live in a single-port-read, single-port-write memory with a
//   registered read. A request walks the stored records one per cycle
//   while the output is free, from the oldest, until the key matches or
//   the stored records run out. One request is in flight at a time and
//   s_tready is high only while the block is idle, so a new request is
//   taken only once the previous response has been registered.
//   A set that matches rewrites that record; a new key is appended in the
//   same cycle the response is registered.
//   Reset empties the table at once (record count to zero); the memory
//   itself is never cleared because entries past the count are never read.
//   If the receiver holds m_tready low, a finished response stays in the
//   output register and the next search makes no progress until it is taken.
// ----------------------------------------------------------------------------
module file_permission_table
	import fpt_pkg::*;
#(
	parameter int ENTRIES  = 64,
	parameter int KEY_BITS = 64,
	parameter int ID_BITS  = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// file_key[63:0], owner_id[95:64], perm_bits[104:96], user_id[136:105],
	// is_group[137], action[139:138], zero[143:140]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// req_type[0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// ok[0], status[3:1], zero[7:4]
	output logic [OUT_DATA_W-1:0] m_tdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ID_USE = (ID_BITS < ID_IN_W) ? ID_BITS : ID_IN_W;
	localparam int WORD_W = KEY_BITS + ID_BITS + PERM_W;

	fsm_t state_q, state_nx;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    issue_q;
	logic                rv_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [WORD_W-1:0]   rd_s1;

	req_t                req_q;
	logic [KEY_BITS-1:0] key_q;
	logic [ID_BITS-1:0]  owner_q;
	logic [PERM_W-1:0]   perm_q;
	logic [ID_BITS-1:0]  user_q;
	logic                grp_q;
	act_t                act_q;

	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [WORD_W-1:0]   mem [ENTRIES];

	logic                accept;
	logic                out_free;
	logic                step;
	logic                rd_en;
	logic                key_hit;
	logic                last_rec;
	logic                found_now;
	logic                done;
	logic [IDX_W-1:0]    wr_addr;
	lookup_t             lk;
	result_t             res;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// stored word: key in the high bits, then owner, then perm
	assign key_hit   = rd_s1[WORD_W-1 -: KEY_BITS] == key_q;
	assign last_rec  = (CNT_W'(idx_s1) + CNT_W'(1)) == count_q;
	assign found_now = rv_s1 && key_hit;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				if (done && out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_tready = 1'b0;
		done     = 1'b0;
		step     = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_SCAN: begin
				done = (count_q == '0) || found_now || (rv_s1 && last_rec);
				step = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign rd_en = step && (issue_q < count_q);

	always_comb begin
		lk.req_type    = req_q;
		lk.found       = found_now;
		lk.full        = count_q == CNT_W'(ENTRIES);
		lk.owner_match = rd_s1[PERM_W +: ID_BITS] == user_q;
		lk.is_group    = grp_q;
		lk.action      = act_q;
		lk.perm        = rd_s1[PERM_W-1:0];
	end

	fpt_decide u_decide (
		.lk  (lk),
		.res (res)
	);

	assign wr_addr = found_now ? idx_s1 : count_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			rv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				issue_q <= '0;
				rv_s1   <= 1'b0;
			end else if (step) begin
				rv_s1 <= rd_en;
				if (rd_en) begin
					issue_q <= issue_q + CNT_W'(1);
				end
			end
			if (done && step) begin
				m_tvalid_q <= 1'b1;
				if (res.append) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// request and pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_t'(s_tuser);
			key_q   <= s_tdata[KEY_LSB +: KEY_BITS];
			owner_q <= ID_BITS'(s_tdata[OWN_LSB +: ID_USE]);
			perm_q  <= s_tdata[PERM_LSB +: PERM_W];
			user_q  <= ID_BITS'(s_tdata[USER_LSB +: ID_USE]);
			grp_q   <= s_tdata[GRP_BIT];
			act_q   <= act_t'(s_tdata[ACT_LSB +: 2]);
		end
		if (rd_en) begin
			idx_s1 <= issue_q[IDX_W-1:0];
		end
		if (done && step) begin
			m_tdata_q <= OUT_DATA_W'({res.status, res.ok});
		end
	end

	// record memory
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= mem[issue_q[IDX_W-1:0]];
		end
		if (done && step && res.wr_en) begin
			mem[wr_addr] <= {key_q, owner_q, perm_q};
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("record count above table size");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		(count_q == $past(count_q) + CNT_W'(1)) && $past(req_q == REQ_SET))
		else $error("record count moved other than by an append");

	a_resp_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == S_SCAN))
		else $error("response raised outside a search");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> !s_tready)
		else $error("request taken during a search");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s1 |-> (CNT_W'(idx_s1) < count_q))
		else $error("read beyond stored records");

endmodule

### sv/fpt_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpt_decide
// Turns the outcome of a key search into the response and the table update.
// ----------------------------------------------------------------------------
module fpt_decide
	import fpt_pkg::*;
(
	input  lookup_t lk,
	output result_t res
);

	logic [2:0] cls;
	logic       grant;

	// owner wins over group, group over other
	always_comb begin
		if (lk.owner_match) begin
			cls = lk.perm[8:6];
		end else if (lk.is_group) begin
			cls = lk.perm[5:3];
		end else begin
			cls = lk.perm[2:0];
		end
	end

	always_comb begin
		case (lk.action)
			ACT_READ:  grant = cls[2];
			ACT_WRITE: grant = cls[1];
			ACT_EXEC:  grant = cls[0];
			default:   grant = 1'b0;
		endcase
	end

	always_comb begin
		res = '{ok: 1'b0, status: ST_OK, wr_en: 1'b0, append: 1'b0};
		case (lk.req_type)
			REQ_SET: begin
				if (lk.found) begin
					res = '{ok: 1'b1, status: ST_OK, wr_en: 1'b1, append: 1'b0};
				end else if (lk.full) begin
					res = '{ok: 1'b0, status: ST_FULL, wr_en: 1'b0, append: 1'b0};
				end else begin
					res = '{ok: 1'b1, status: ST_OK, wr_en: 1'b1, append: 1'b1};
				end
			end
			REQ_CHECK: begin
				if (!lk.found) begin
					res.status = ST_NOTFOUND;
				end else if (lk.action == ACT_BAD) begin
					res.status = ST_BADACT;
				end else if (grant) begin
					res.ok     = 1'b1;
					res.status = ST_OK;
				end else begin
					res.status = ST_DENIED;
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

endmodule
